### src/assert_macros.svh
// Assertion macros shared by the point-in-polygon RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define PIP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define PIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pip_pkg.sv
// Package for the point-in-polygon tester: sizes, command/status structs.
// No dependencies; imported by the controller, the datapath and the top level.
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 16;
  localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int VTX_W        = 2 * COORD_W;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic              load_en;    // vertex transfer accepted
    logic              test_en;    // test transfer accepted
    logic              rd_en;      // vertex store read
    logic              rd_edge;    // read closes an edge (else primes previous vertex)
    logic [ADDR_W-1:0] rd_addr;
    logic              emit_rej;   // result from bounding box reject
    logic              emit_walk;  // result from edge walk
  } pip_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             reject;      // current test point fails box check
    logic [CNT_W-1:0] total;       // vertices stored
  } pip_sts_t;

endpackage

### src/pip_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/pip_ctrl.sv
// Controller for the point-in-polygon tester: accepts transfers and sequences the edge walk.
// Depends on pip_pkg.
module pip_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_cmd,
  output logic              busy,
  input  pip_pkg::pip_sts_t sts_i,
  output pip_pkg::pip_cmd_t cmd_o
);
  import pip_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PRIME = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DRAIN = 4'b1000
  } pip_state_t;

  // read-to-result depth of the datapath, minus one
  localparam logic [1:0] DRAIN_LAST = 2'd3;

  pip_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [1:0]        drain_r, drain_nxt;
  logic [ADDR_W-1:0] last_addr;
  logic              accept;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign last_addr = ADDR_W'(sts_i.total - CNT_W'(1));

  // next state and commands
  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    drain_nxt         = drain_r;
    cmd_o             = '0;
    cmd_o.load_en     = accept && (in_cmd == CMD_LOAD);
    cmd_o.test_en     = accept && (in_cmd == CMD_TEST);
    case (state_r)
      ST_IDLE: begin
        if (cmd_o.test_en) begin
          if (sts_i.reject) begin
            cmd_o.emit_rej = 1'b1;
          end else begin
            state_nxt = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        // previous vertex of edge 0 is the last one stored
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = last_addr;
        idx_nxt       = '0;
        state_nxt     = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_edge = 1'b1;
        cmd_o.rd_addr = idx_r;
        idx_nxt       = idx_r + ADDR_W'(1);
        if (idx_r == last_addr) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == DRAIN_LAST) begin
          cmd_o.emit_walk = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

### src/pip_dpath.sv
// Datapath for the point-in-polygon tester: vertex store, bounding box and crossing pipeline.
// Depends on pip_pkg and pip_ram.
module pip_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pip_pkg::pip_cmd_t                  cmd_i,
  output pip_pkg::pip_sts_t                  sts_o,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_y,
  input  logic                               in_first_vertex,
  output logic                               out_valid,
  output logic                               out_inside_res,
  output logic                               out_box_reject,
  output logic                               out_overflowed
);
  import pip_pkg::*;

  // polygon state
  logic [CNT_W-1:0]          total_r, total_nxt;
  logic signed [COORD_W-1:0] min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic signed [COORD_W-1:0] min_y_r, min_y_nxt, max_y_r, max_y_nxt;
  logic                      drop_r, drop_nxt;
  logic [CNT_W-1:0]          eff_total;
  logic                      eff_drop;
  logic                      full;
  logic                      we;

  // test point and walk
  logic signed [COORD_W-1:0] tx_r, ty_r;
  logic [VTX_W-1:0]          rdata;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic                      va_r, va_edge_r;
  logic                      vb_r, vc_r;
  logic signed [DIFF_W-1:0]  e_cx, e_cy, e_px, e_py, e_tx, e_ty;
  logic signed [DIFF_W-1:0]  a_r, d_r, e_r, f_r;
  logic                      strad_b_r, dpos_b_r, strad_c_r, dpos_c_r;
  logic signed [PROD_W-1:0]  p1_r, p2_r;
  logic                      hit;
  logic                      odd_r;
  logic                      out_valid_r;

  // restart and capacity for a vertex transfer
  assign eff_total = in_first_vertex ? '0 : total_r;
  assign eff_drop  = in_first_vertex ? 1'b0 : drop_r;
  assign full      = (eff_total == CNT_W'(MAX_VERTICES));
  assign we        = cmd_i.load_en && !full;

  always_comb begin
    total_nxt = total_r;
    drop_nxt  = drop_r;
    min_x_nxt = min_x_r;
    max_x_nxt = max_x_r;
    min_y_nxt = min_y_r;
    max_y_nxt = max_y_r;
    if (cmd_i.load_en) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        total_nxt = eff_total + CNT_W'(1);
        drop_nxt  = eff_drop;
        if (eff_total == '0) begin
          min_x_nxt = in_coord_x;
          max_x_nxt = in_coord_x;
          min_y_nxt = in_coord_y;
          max_y_nxt = in_coord_y;
        end else begin
          if (in_coord_x < min_x_r) min_x_nxt = in_coord_x;
          if (in_coord_x > max_x_r) max_x_nxt = in_coord_x;
          if (in_coord_y < min_y_r) min_y_nxt = in_coord_y;
          if (in_coord_y > max_y_r) max_y_nxt = in_coord_y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      drop_r  <= 1'b0;
      min_x_r <= '0;
      max_x_r <= '0;
      min_y_r <= '0;
      max_y_r <= '0;
    end else begin
      total_r <= total_nxt;
      drop_r  <= drop_nxt;
      min_x_r <= min_x_nxt;
      max_x_r <= max_x_nxt;
      min_y_r <= min_y_nxt;
      max_y_r <= max_y_nxt;
    end
  end

  // bounding box check on the incoming point; box edge counts as inside
  assign sts_o.reject = (total_r == '0) ||
                        (in_coord_x < min_x_r) || (in_coord_x > max_x_r) ||
                        (in_coord_y < min_y_r) || (in_coord_y > max_y_r);
  assign sts_o.total  = total_r;

  // vertex store, x in the upper half
  pip_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (eff_total[ADDR_W-1:0]),
    .wdata ({in_coord_x, in_coord_y}),
    .re    (cmd_i.rd_en),
    .raddr (cmd_i.rd_addr),
    .rdata (rdata)
  );

  assign cur_x = rdata[VTX_W-1:COORD_W];
  assign cur_y = rdata[COORD_W-1:0];

  // test point capture
  always_ff @(posedge clk) begin
    if (cmd_i.test_en) begin
      tx_r <= in_coord_x;
      ty_r <= in_coord_y;
    end
  end

  // stage A: read data tag and previous vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      va_edge_r <= 1'b0;
    end else begin
      va_r      <= cmd_i.rd_en;
      va_edge_r <= cmd_i.rd_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (va_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
  end

  // stage B: differences and straddle test (current vertex i, previous j)
  assign e_cx = {cur_x[COORD_W-1], cur_x};
  assign e_cy = {cur_y[COORD_W-1], cur_y};
  assign e_px = {prev_x_r[COORD_W-1], prev_x_r};
  assign e_py = {prev_y_r[COORD_W-1], prev_y_r};
  assign e_tx = {tx_r[COORD_W-1], tx_r};
  assign e_ty = {ty_r[COORD_W-1], ty_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r && va_edge_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= e_tx - e_cx;
    d_r       <= e_py - e_cy;
    e_r       <= e_px - e_cx;
    f_r       <= e_ty - e_cy;
    strad_b_r <= (cur_y > ty_r) != (prev_y_r > ty_r);
    dpos_b_r  <= (prev_y_r > cur_y);
  end

  // stage C: cross products, exact in PROD_W bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r      <= PROD_W'(a_r) * PROD_W'(d_r);
    p2_r      <= PROD_W'(e_r) * PROD_W'(f_r);
    strad_c_r <= strad_b_r;
    dpos_c_r  <= dpos_b_r;
  end

  // stage D: crossing decision and parity
  assign hit = strad_c_r && (dpos_c_r ? (p1_r < p2_r) : (p1_r > p2_r));

  always_ff @(posedge clk) begin
    if (cmd_i.test_en) begin
      odd_r <= 1'b0;
    end else if (vc_r && hit) begin
      odd_r <= !odd_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.emit_rej || cmd_i.emit_walk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit_rej) begin
      out_inside_res <= 1'b0;
      out_box_reject <= 1'b1;
      out_overflowed <= drop_r;
    end else if (cmd_i.emit_walk) begin
      out_inside_res <= odd_r;
      out_box_reject <= 1'b0;
      out_overflowed <= drop_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### src/point_in_polygon_test.sv
// Point-in-polygon tester (crossing-number rule) on Q12.4 coordinates, N stored vertices.
// Vertex transfer: no result. Test outside the box: result strobed the cycle after.
// Walked test: busy through the prime, walk and drain states, result strobed right after; a new test waits until idle.
// The walk reads one vertex per cycle from the single-read-port vertex store.
// Synchronous active-low reset empties the polygon and clears box and overflow flag.
// Top level; depends on pip_pkg, pip_ctrl, pip_dpath, pip_ram and assert_macros.svh.
`include "assert_macros.svh"
module point_in_polygon_test (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_cmd,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_y,
  input  logic                               in_first_vertex,
  output logic                               out_valid,
  output logic                               out_inside_res,
  output logic                               out_box_reject,
  output logic                               out_overflowed
);
  import pip_pkg::*;

  pip_cmd_t cmd;
  pip_sts_t sts;

  // controller
  pip_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath
  pip_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_first_vertex (in_first_vertex),
    .out_valid       (out_valid),
    .out_inside_res  (out_inside_res),
    .out_box_reject  (out_box_reject),
    .out_overflowed  (out_overflowed)
  );

  // a result only ever appears once the walk has finished
  `PIP_ASSERT_NOW(a_res_idle, clk, rst_n, out_valid, !busy, "result while busy")
  // a test transfer either answers at once or starts the walk
  `PIP_ASSERT_NEXT(a_test_resp, clk, rst_n, start && !busy && (in_cmd == CMD_TEST),
    out_valid || busy, "test transfer neither answered nor walked")
  // a vertex transfer never produces a result
  `PIP_ASSERT_NEXT(a_load_quiet, clk, rst_n, start && !busy && (in_cmd == CMD_LOAD),
    !out_valid && !busy, "vertex transfer produced a result")

endmodule
